// ===== src/bcomp_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared types, constants and helpers for the compensation block.
// ----------------------------------------------------------------------------
package bcomp_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CAL_A    = 2'd0,
    REG_CAL_B    = 2'd1,
    REG_CAL_C    = 2'd2,
    REG_OVERSAMP = 2'd3
  } bcomp_reg_t;

  // Conversion kinds carried in the op field.
  typedef enum logic {
    OP_TEMP  = 1'b0,
    OP_PRESS = 1'b1
  } bcomp_op_t;

  // Compensation constants from the datasheet algorithm.
  localparam logic [31:0] TEMP_OFFSET = 32'd4000;
  localparam logic [31:0] PCOEF_A     = 32'd3038;
  localparam logic [31:0] PCOEF_B     = 32'd7357;
  localparam logic [31:0] PCOEF_C     = 32'd3791;
  localparam logic [31:0] B7_SCALE    = 32'd50000;
  localparam logic [31:0] B4_BIAS     = 32'd32768;
  localparam logic [31:0] ROUND_TEMP  = 32'd8;
  localparam logic [31:0] ROUND_TWO   = 32'd2;

  // Request to the shared divider.
  typedef struct packed {
    logic start;
    logic signed_op;
  } bcomp_div_ctl_t;

  // Arithmetic (flooring) right shift of a 32-bit word.
  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
    logic signed [31:0] s;
    s = v;
    return $unsigned(s >>> n);
  endfunction

  // Sign extension of a 16-bit coefficient to 32 bits.
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ===== src/bcomp_if.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation channel interfaces
// Valid/ready channels for raw readings and compensated results.
// ----------------------------------------------------------------------------

// Raw reading channel.
interface bcomp_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [23:0] raw_reading;

  modport source (output valid, output op, output raw_reading, input ready);
  modport sink   (input valid, input op, input raw_reading, output ready);
endinterface

// Compensated result channel.
interface bcomp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               div_fault;

  modport source (output valid, output value, output div_fault, input ready);
  modport sink   (input valid, input value, input div_fault, output ready);
endinterface

// ===== src/bcomp_div.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation divider
// Radix-2 restoring divider, one quotient bit per cycle, signed or unsigned.
// ----------------------------------------------------------------------------
module bcomp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  bcomp_pkg::bcomp_div_ctl_t ctl,
  input  logic [31:0]               dividend,
  input  logic [31:0]               divisor,
  output logic                      done,
  output logic [31:0]               quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] divs;
  logic        neg_q;
  logic [32:0] rem_shift;
  logic [32:0] rem_diff;
  logic        a_neg;
  logic        b_neg;

  // Operand signs matter only for signed division.
  assign a_neg = ctl.signed_op & dividend[31];
  assign b_neg = ctl.signed_op & divisor[31];

  // One trial subtraction per cycle.
  assign rem_shift = {rem, quo[31]};
  assign rem_diff  = rem_shift - {1'b0, divs};

  // Iteration control and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        cnt   <= 5'd31;
        rem   <= '0;
        quo   <= a_neg ? (32'd0 - dividend) : dividend;
        divs  <= b_neg ? (32'd0 - divisor) : divisor;
        neg_q <= a_neg ^ b_neg;
      end else if (busy) begin
        if (!rem_diff[32]) begin
          rem <= rem_diff[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_shift[31:0];
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient sign is restored on the way out; it wraps like the C cast.
  assign quotient = neg_q ? (32'd0 - quo) : quo;

endmodule

// ===== src/barometer_compensation_top.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation top level
// Integer temperature and pressure compensation on one shared multiplier
// and one shared divider, stepped by a one-hot sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  reading   in         valid/ready        op, raw_reading
//  report    out        valid/ready        value, div_fault
//  config    in         cfg_we, no wait    cfg_index, cfg_data
//
//  Both transactions pass through the bit-serial divider; a zero divisor
//  skips it and reports a divisor fault. Ready is high only when idle.
//  A finished result waits in the output register while a new reading may be
//  taken; the sequencer holds its next result until the register frees.
//  Synchronous reset clears the sequencer, the configuration and the B5 term.
// ----------------------------------------------------------------------------
module barometer_compensation_top (
  input  logic         clk,
  input  logic         rst,
  bcomp_in_if.sink     reading,
  bcomp_out_if.source  report,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam int NST = 30;

  typedef enum logic [NST-1:0] {
    ST_IDLE = NST'(1) << 0,
    ST_T0   = NST'(1) << 1,
    ST_T1   = NST'(1) << 2,
    ST_T2   = NST'(1) << 3,
    ST_TDIV = NST'(1) << 4,
    ST_P0   = NST'(1) << 5,
    ST_P1   = NST'(1) << 6,
    ST_P2   = NST'(1) << 7,
    ST_P3   = NST'(1) << 8,
    ST_P4   = NST'(1) << 9,
    ST_P5   = NST'(1) << 10,
    ST_P6   = NST'(1) << 11,
    ST_P7   = NST'(1) << 12,
    ST_P8   = NST'(1) << 13,
    ST_P9   = NST'(1) << 14,
    ST_P10  = NST'(1) << 15,
    ST_P11  = NST'(1) << 16,
    ST_P12  = NST'(1) << 17,
    ST_P13  = NST'(1) << 18,
    ST_P14  = NST'(1) << 19,
    ST_P15  = NST'(1) << 20,
    ST_PDIV = NST'(1) << 21,
    ST_P16  = NST'(1) << 22,
    ST_P17  = NST'(1) << 23,
    ST_P18  = NST'(1) << 24,
    ST_P19  = NST'(1) << 25,
    ST_P20  = NST'(1) << 26,
    ST_FIN  = NST'(1) << 27,
    ST_TZ   = NST'(1) << 28,
    ST_PZ   = NST'(1) << 29
  } state_t;

  state_t      state;

  // Configuration registers.
  logic [63:0] cal_word_a;
  logic [63:0] cal_word_b;
  logic [31:0] cal_word_c;
  logic [1:0]  oversampling;

  // Kept B5 term and working registers.
  logic [31:0] temp_term;
  logic [31:0] raw;
  logic [31:0] prod;
  logic [31:0] t1;
  logic [31:0] sq;
  logic [31:0] b6;
  logic [31:0] up;
  logic [31:0] b3;
  logic [31:0] b4;
  logic [31:0] p;
  logic [31:0] res;
  logic        fault;
  logic        post_shift;

  // Output register.
  logic        out_valid;
  logic [31:0] out_value;
  logic        out_fault;

  // Shared multiplier operands and divider hookup.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_lo;
  bcomp_pkg::bcomp_div_ctl_t div_ctl;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [31:0] div_q;

  // Coefficients unpacked from the calibration words.
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] den;
  logic [31:0] tsum;

  assign ac1 = bcomp_pkg::sx16(cal_word_a[63:48]);
  assign ac2 = bcomp_pkg::sx16(cal_word_a[47:32]);
  assign ac3 = bcomp_pkg::sx16(cal_word_a[31:16]);
  assign ac4 = {16'd0, cal_word_a[15:0]};
  assign ac5 = {16'd0, cal_word_b[63:48]};
  assign ac6 = {16'd0, cal_word_b[47:32]};
  assign b1  = bcomp_pkg::sx16(cal_word_b[31:16]);
  assign b2  = bcomp_pkg::sx16(cal_word_b[15:0]);
  assign mc  = bcomp_pkg::sx16(cal_word_c[31:16]);
  assign md  = bcomp_pkg::sx16(cal_word_c[15:0]);

  // Temperature divisor and the new B5 term.
  assign den  = t1 + md;
  assign tsum = t1 + div_q;

  // Handshake outputs.
  assign reading.ready    = (state == ST_IDLE) && !rst;
  assign report.valid     = out_valid;
  assign report.value     = out_value;
  assign report.div_fault = out_fault;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_word_a   <= '0;
      cal_word_b   <= '0;
      cal_word_c   <= '0;
      oversampling <= '0;
    end else if (cfg_we) begin
      unique case (bcomp_pkg::bcomp_reg_t'(cfg_index))
        bcomp_pkg::REG_CAL_A:    cal_word_a   <= cfg_data;
        bcomp_pkg::REG_CAL_B:    cal_word_b   <= cfg_data;
        bcomp_pkg::REG_CAL_C:    cal_word_c   <= cfg_data[31:0];
        bcomp_pkg::REG_OVERSAMP: oversampling <= cfg_data[1:0];
        default:                 cal_word_a   <= cal_word_a;
      endcase
    end
  end

  // Multiplier operand selection per sequencer step.
  always_comb begin
    mul_a = prod;
    mul_b = prod;
    unique case (state)
      ST_T0:   begin mul_a = raw - ac6;              mul_b = ac5;  end
      ST_P1:   begin mul_a = b6;                     mul_b = b6;   end
      ST_P3:   begin mul_a = b2;                     mul_b = sq;   end
      ST_P5:   begin mul_a = ac2;                    mul_b = b6;   end
      ST_P8:   begin mul_a = ac3;                    mul_b = b6;   end
      ST_P10:  begin mul_a = b1;                     mul_b = sq;   end
      ST_P12:  begin mul_a = ac4;                    mul_b = t1 + bcomp_pkg::B4_BIAS; end
      ST_P14:  begin mul_a = up - b3;
                     mul_b = bcomp_pkg::B7_SCALE >> oversampling; end
      ST_P16:  begin mul_a = bcomp_pkg::asr32(p, 5'd8);
                     mul_b = bcomp_pkg::asr32(p, 5'd8); end
      ST_P17:  begin mul_a = prod;                   mul_b = bcomp_pkg::PCOEF_A; end
      ST_P19:  begin mul_a = 32'd0 - bcomp_pkg::PCOEF_B; mul_b = p; end
      default: begin mul_a = prod;                   mul_b = prod; end
    endcase
  end

  assign mul_lo = mul_a * mul_b;

  // Divider requests: signed for temperature, unsigned for pressure.
  always_comb begin
    div_ctl.start     = 1'b0;
    div_ctl.signed_op = 1'b0;
    div_dividend      = prod;
    div_divisor       = b4;
    if (state == ST_T2) begin
      div_ctl.start     = (den != 32'd0);
      div_ctl.signed_op = 1'b1;
      div_dividend      = mc << 11;
      div_divisor       = den;
    end else if (state == ST_P15) begin
      div_ctl.start     = (b4 != 32'd0);
      div_dividend      = prod[31] ? prod : {prod[30:0], 1'b0};
    end
  end

  bcomp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      temp_term <= '0;
      out_valid <= 1'b0;
    end else begin
      // The finishing step reloads the output register itself.
      if (report.valid && report.ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (reading.valid) begin
            if (bcomp_pkg::bcomp_op_t'(reading.op) == bcomp_pkg::OP_TEMP) begin
              raw   <= {16'd0, reading.raw_reading[15:0]};
              state <= ST_T0;
            end else begin
              raw   <= {8'd0, reading.raw_reading};
              state <= ST_P0;
            end
          end
        end
        // Temperature: X1, then B5 = X1 + MC*2^11 / (X1 + MD).
        ST_T0: begin
          prod  <= mul_lo;
          state <= ST_T1;
        end
        ST_T1: begin
          t1    <= bcomp_pkg::asr32(prod, 5'd15);
          state <= ST_T2;
        end
        ST_T2: begin
          state <= (den == 32'd0) ? ST_TZ : ST_TDIV;
        end
        ST_TDIV: begin
          if (div_done) begin
            temp_term <= tsum;
            res       <= bcomp_pkg::asr32(tsum + bcomp_pkg::ROUND_TEMP, 5'd4);
            fault     <= 1'b0;
            state     <= ST_FIN;
          end
        end
        ST_TZ, ST_PZ: begin
          res   <= '0;
          fault <= 1'b1;
          state <= ST_FIN;
        end
        // Pressure: B6 and the shifted raw reading.
        ST_P0: begin
          b6    <= temp_term - bcomp_pkg::TEMP_OFFSET;
          up    <= raw >> (4'd8 - {2'd0, oversampling});
          state <= ST_P1;
        end
        ST_P1: begin
          prod  <= mul_lo;
          state <= ST_P2;
        end
        ST_P2: begin
          sq    <= bcomp_pkg::asr32(prod, 5'd12);
          state <= ST_P3;
        end
        ST_P3: begin
          prod  <= mul_lo;
          state <= ST_P4;
        end
        ST_P4: begin
          t1    <= bcomp_pkg::asr32(prod, 5'd11);
          state <= ST_P5;
        end
        ST_P5: begin
          prod  <= mul_lo;
          state <= ST_P6;
        end
        ST_P6: begin
          t1    <= t1 + bcomp_pkg::asr32(prod, 5'd11);
          state <= ST_P7;
        end
        // B3 from AC1 and the summed X terms.
        ST_P7: begin
          b3    <= bcomp_pkg::asr32((({ac1[29:0], 2'b00} + t1) << oversampling)
                                    + bcomp_pkg::ROUND_TWO, 5'd2);
          state <= ST_P8;
        end
        ST_P8: begin
          prod  <= mul_lo;
          state <= ST_P9;
        end
        ST_P9: begin
          t1    <= bcomp_pkg::asr32(prod, 5'd13);
          state <= ST_P10;
        end
        ST_P10: begin
          prod  <= mul_lo;
          state <= ST_P11;
        end
        ST_P11: begin
          t1    <= bcomp_pkg::asr32(t1 + bcomp_pkg::asr32(prod, 5'd16)
                                    + bcomp_pkg::ROUND_TWO, 5'd2);
          state <= ST_P12;
        end
        ST_P12: begin
          prod  <= mul_lo;
          state <= ST_P13;
        end
        ST_P13: begin
          b4    <= prod >> 15;
          state <= ST_P14;
        end
        // B7 stays in the product register for the division.
        ST_P14: begin
          prod  <= mul_lo;
          state <= ST_P15;
        end
        ST_P15: begin
          post_shift <= prod[31];
          state      <= (b4 == 32'd0) ? ST_PZ : ST_PDIV;
        end
        ST_PDIV: begin
          if (div_done) begin
            p     <= post_shift ? {div_q[30:0], 1'b0} : div_q;
            state <= ST_P16;
          end
        end
        // Final pressure correction.
        ST_P16: begin
          prod  <= mul_lo;
          state <= ST_P17;
        end
        ST_P17: begin
          prod  <= mul_lo;
          state <= ST_P18;
        end
        ST_P18: begin
          t1    <= bcomp_pkg::asr32(prod, 5'd16);
          state <= ST_P19;
        end
        ST_P19: begin
          prod  <= mul_lo;
          state <= ST_P20;
        end
        ST_P20: begin
          res   <= p + bcomp_pkg::asr32(t1 + bcomp_pkg::asr32(prod, 5'd16)
                                        + bcomp_pkg::PCOEF_C, 5'd4);
          fault <= 1'b0;
          state <= ST_FIN;
        end
        // Hand the result to the output register once it is free.
        ST_FIN: begin
          if (!out_valid || report.ready) begin
            out_valid <= 1'b1;
            out_value <= res;
            out_fault <= fault;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation testbench
// Drives raw temperature and pressure readings through the valid/ready
// channels and checks every compensated report against a known table value or
// a cycle-free model of the integer compensation, with calibration changed between runs.
// ----------------------------------------------------------------------------
module testbench;

  // Kinds of rows in the directed stimulus table.
  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  // One directed step: either a reading to send or a register to load.
  typedef struct packed {
    row_kind_t             kind;
    bcomp_pkg::bcomp_op_t  op;
    logic [23:0]           raw;
    logic                  known;
    logic [31:0]           want_value;
    logic                  want_fault;
    bcomp_pkg::bcomp_reg_t sel;
    logic [63:0]           word;
  } row_t;

  // One compensated report.
  typedef struct packed {
    logic [31:0] value;
    logic        div_fault;
  } report_t;

  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int SEGMENTS      = 9;
  localparam int SEGMENT_ITEMS = 150;

  // Compensation constants of the integer algorithm.
  localparam logic [31:0] B5_OFFSET  = 32'd4000;
  localparam logic [31:0] POLY_SQ    = 32'd3038;
  localparam logic [31:0] POLY_LIN   = 32'd7357;
  localparam logic [31:0] POLY_BIAS  = 32'd3791;
  localparam logic [31:0] B7_FACTOR  = 32'd50000;
  localparam logic [31:0] B7_TOP     = 32'h8000_0000;
  localparam logic [31:0] B4_OFFSET  = 32'd32768;

  // Typical coefficients: ac1 ac2 ac3 ac4 ac5 ac6 b1 b2 mc md.
  localparam logic [15:0] NOMINAL_COEF [10] = '{
    16'h0198, 16'hFFB8, 16'hC7D1, 16'h7FE5, 16'h7FF5,
    16'h5A71, 16'h182E, 16'h0004, 16'hDDF9, 16'h0B34
  };
  localparam logic [15:0] EDGE_COEF [5] = '{
    16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h0000
  };

  localparam int DIRECTED_ROWS = 39;
  localparam row_t STEPS [DIRECTED_ROWS] = '{
    // Everything zero after reset: both divisors are zero.
    '{ROW_ITEM, bcomp_pkg::OP_PRESS, 24'h000000, 1'b1, 32'd0, 1'b1,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_ITEM, bcomp_pkg::OP_TEMP,  24'h000000, 1'b1, 32'd0, 1'b1,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_ITEM, bcomp_pkg::OP_TEMP,  24'hFFFFFF, 1'b1, 32'd0, 1'b1,
      bcomp_pkg::REG_CAL_A, 64'h0},
    // Typical calibration, junk above the narrow registers.
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A,    64'h0198_FFB8_C7D1_7FE5},
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_B,    64'h7FF5_5A71_182E_0004},
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_C,    64'hA5A5_A5A5_DDF9_0B34},
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_OVERSAMP, 64'hFFFF_FFFF_FFFF_FFFC},
    // Worked example: 15.0 degrees and 69964 Pa.
    '{ROW_ITEM, bcomp_pkg::OP_TEMP,  24'h006CFA, 1'b1, 32'd150,   1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_ITEM, bcomp_pkg::OP_PRESS, 24'h5D2300, 1'b1, 32'd69964, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_ITEM, bcomp_pkg::OP_PRESS, 24'h000000, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_ITEM, bcomp_pkg::OP_PRESS, 24'hFFFFFF, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_ITEM, bcomp_pkg::OP_TEMP,  24'hFF0000, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_ITEM, bcomp_pkg::OP_TEMP,  24'h00FFFF, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    // Upper byte of a temperature reading is ignored.
    '{ROW_ITEM, bcomp_pkg::OP_TEMP,  24'hAB6CFA, 1'b1, 32'd150, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    // Each oversampling setting on the pressure path.
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_OVERSAMP, 64'h0000_0000_0000_0003},
    '{ROW_ITEM, bcomp_pkg::OP_PRESS, 24'h5D2300, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_ITEM, bcomp_pkg::OP_PRESS, 24'hFFFFFF, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_ITEM, bcomp_pkg::OP_PRESS, 24'h000000, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_OVERSAMP, 64'h0000_0000_0000_0001},
    '{ROW_ITEM, bcomp_pkg::OP_PRESS, 24'h800000, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_OVERSAMP, 64'h0000_0000_0000_0002},
    '{ROW_ITEM, bcomp_pkg::OP_PRESS, 24'h7FFFFF, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    // ac4 of zero makes the pressure divisor zero.
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A,    64'h0198_FFB8_C7D1_0000},
    '{ROW_ITEM, bcomp_pkg::OP_PRESS, 24'h5D2300, 1'b1, 32'd0, 1'b1,
      bcomp_pkg::REG_CAL_A, 64'h0},
    // ac5 and md of zero make the temperature divisor zero; B5 is kept.
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_B,    64'h0000_5A71_182E_0004},
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_C,    64'h0000_0000_DDF9_0000},
    '{ROW_ITEM, bcomp_pkg::OP_TEMP,  24'h001234, 1'b1, 32'd0, 1'b1,
      bcomp_pkg::REG_CAL_A, 64'h0},
    // All coefficient fields at 0xFFFF (minus one, but 65535 for ac4 to ac6); the first pressure uses the kept B5.
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A,    64'hFFFF_FFFF_FFFF_FFFF},
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_B,    64'hFFFF_FFFF_FFFF_FFFF},
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_C,    64'hFFFF_FFFF_FFFF_FFFF},
    '{ROW_ITEM, bcomp_pkg::OP_PRESS, 24'h5D2300, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_ITEM, bcomp_pkg::OP_TEMP,  24'h00FFFF, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_ITEM, bcomp_pkg::OP_TEMP,  24'h000000, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_ITEM, bcomp_pkg::OP_PRESS, 24'hFFFFFF, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    // Coefficient fields at 0x8000: most negative for the signed ones.
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A,    64'h8000_8000_8000_8000},
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_B,    64'h8000_8000_8000_8000},
    '{ROW_CFG,  bcomp_pkg::OP_TEMP,  24'h0, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_C,    64'h0000_0000_8000_8000},
    '{ROW_ITEM, bcomp_pkg::OP_TEMP,  24'h007FFF, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0},
    '{ROW_ITEM, bcomp_pkg::OP_PRESS, 24'h5D2300, 1'b0, 32'd0, 1'b0,
      bcomp_pkg::REG_CAL_A, 64'h0}
  };

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  bcomp_in_if  reading_ch ();
  bcomp_out_if report_ch ();

  barometer_compensation_top dut (
    .clk       (clk),
    .rst       (rst),
    .reading   (reading_ch),
    .report    (report_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model copy of the configuration and the kept B5 term.
  logic [63:0] coef_word_a = '0;
  logic [63:0] coef_word_b = '0;
  logic [31:0] coef_word_c = '0;
  logic [1:0]  oss_setting = '0;
  logic [31:0] b5_kept     = '0;

  report_t pending_reports [$];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int failures        = 0;
  int reports_checked = 0;
  int faults_seen     = 0;
  int temp_sent       = 0;
  int press_sent      = 0;
  int reg_writes      = 0;
  int quiet_cycles    = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Integer compensation of one reading; a temperature without a divisor fault updates the kept B5.
  function automatic report_t compensate_reading(input bcomp_pkg::bcomp_op_t op,
                                                 input logic [23:0] raw);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] t, x1, x2, x3, den, up, b3, b4, b6, b7, sq, p;
    logic signed [31:0] num, dvs;
    longint quot;
    report_t r;
    ac1 = bcomp_pkg::sx16(coef_word_a[63:48]);
    ac2 = bcomp_pkg::sx16(coef_word_a[47:32]);
    ac3 = bcomp_pkg::sx16(coef_word_a[31:16]);
    ac4 = {16'b0, coef_word_a[15:0]};
    ac5 = {16'b0, coef_word_b[63:48]};
    ac6 = {16'b0, coef_word_b[47:32]};
    b1  = bcomp_pkg::sx16(coef_word_b[31:16]);
    b2  = bcomp_pkg::sx16(coef_word_b[15:0]);
    mc  = bcomp_pkg::sx16(coef_word_c[31:16]);
    md  = bcomp_pkg::sx16(coef_word_c[15:0]);
    r = '0;
    if (op == bcomp_pkg::OP_TEMP) begin
      t = ({16'b0, raw[15:0]} - ac6) * ac5;
      x1 = $signed(t) >>> 15;
      den = x1 + md;
      if (den == 32'd0) begin
        r.div_fault = 1'b1;
      end else begin
        // Signed quotient truncates toward zero.
        num = mc << 11;
        dvs = den;
        quot = longint'(num) / longint'(dvs);
        x2 = quot[31:0];
        b5_kept = x1 + x2;
        t = b5_kept + 32'd8;
        r.value = $signed(t) >>> 4;
      end
    end else begin
      up = {8'b0, raw} >> (8 - oss_setting);
      b6 = b5_kept - B5_OFFSET;
      t = b6 * b6;
      sq = $signed(t) >>> 12;
      t = b2 * sq;
      x1 = $signed(t) >>> 11;
      t = ac2 * b6;
      x2 = $signed(t) >>> 11;
      x3 = x1 + x2;
      t = ((ac1 * 32'd4 + x3) << oss_setting) + 32'd2;
      b3 = $signed(t) >>> 2;
      t = ac3 * b6;
      x1 = $signed(t) >>> 13;
      t = b1 * sq;
      x2 = $signed(t) >>> 16;
      t = x1 + x2 + 32'd2;
      x3 = $signed(t) >>> 2;
      t = ac4 * (x3 + B4_OFFSET);
      b4 = t >> 15;
      b7 = (up - b3) * (B7_FACTOR >> oss_setting);
      if (b4 == 32'd0) begin
        r.div_fault = 1'b1;
      end else begin
        // Unsigned divisions; the doubling goes after the divide for large B7.
        if (b7 < B7_TOP) begin
          p = (b7 << 1) / b4;
        end else begin
          p = (b7 / b4) << 1;
        end
        x1 = $signed(p) >>> 8;
        x1 = x1 * x1;
        t = x1 * POLY_SQ;
        x1 = $signed(t) >>> 16;
        t = (32'd0 - POLY_LIN) * p;
        x2 = $signed(t) >>> 16;
        t = x1 + x2 + POLY_BIAS;
        x3 = $signed(t) >>> 4;
        r.value = p + x3;
      end
    end
    return r;
  endfunction

  // Write one register; the caller lowers the write enable after the last.
  task automatic load_register(input bcomp_pkg::bcomp_reg_t sel, input logic [63:0] word);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= word;
    @(posedge clk);
    case (sel)
      bcomp_pkg::REG_CAL_A: coef_word_a = word;
      bcomp_pkg::REG_CAL_B: coef_word_b = word;
      bcomp_pkg::REG_CAL_C: coef_word_c = word[31:0];
      default:              oss_setting = word[1:0];
    endcase
    reg_writes++;
  endtask

  // Send one reading and queue its expected report once it is accepted.
  task automatic send_reading(input bcomp_pkg::bcomp_op_t op, input logic [23:0] raw,
                              input logic known, input report_t fixed);
    report_t want;
    if ($urandom_range(99) < send_idle_pct) begin
      reading_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    reading_ch.valid       <= 1'b1;
    reading_ch.op          <= op;
    reading_ch.raw_reading <= raw;
    do @(posedge clk); while (!reading_ch.ready);
    want = compensate_reading(op, raw);
    if (known) begin
      want = fixed;
    end
    pending_reports.push_back(want);
    if (op == bcomp_pkg::OP_TEMP) begin
      temp_sent++;
    end else begin
      press_sent++;
    end
  endtask

  // Stop sending and wait until every queued report has come back.
  task automatic settle_block();
    reading_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // New calibration, then a run of mostly temperature readings each followed by one or two pressures.
  task automatic run_segment(input int seg, input int quota);
    logic [15:0] coef [10];
    logic [63:0] word_oss;
    int sent;
    settle_block();
    for (int k = 0; k < 10; k++) begin
      case (seg % 3)
        0:       coef[k] = NOMINAL_COEF[k] + 16'($urandom_range(1023)) - 16'd512;
        1:       coef[k] = 16'($urandom());
        default: coef[k] = EDGE_COEF[$urandom_range(4)];
      endcase
    end
    word_oss = {$urandom(), $urandom()};
    word_oss[1:0] = 2'(seg % 4);
    load_register(bcomp_pkg::REG_CAL_A, {coef[0], coef[1], coef[2], coef[3]});
    load_register(bcomp_pkg::REG_CAL_B, {coef[4], coef[5], coef[6], coef[7]});
    load_register(bcomp_pkg::REG_CAL_C, {$urandom(), coef[8], coef[9]});
    load_register(bcomp_pkg::REG_OVERSAMP, word_oss);
    cfg_we <= 1'b0;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(3) != 0) begin
        send_reading(bcomp_pkg::OP_TEMP,
                     {8'($urandom()), 16'($urandom_range(40000, 15000))}, 1'b0, '0);
        sent++;
        repeat ($urandom_range(2, 1)) begin
          send_reading(bcomp_pkg::OP_PRESS,
                       {16'($urandom_range(50000, 16000)), 8'($urandom())}, 1'b0, '0);
          sent++;
        end
      end else begin
        send_reading(bcomp_pkg::bcomp_op_t'($urandom_range(1)), 24'($urandom()),
                     1'b0, '0);
        sent++;
      end
    end
  endtask

  // Receiver stalls at random.
  always @(posedge clk) begin
    report_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted report with the oldest expectation.
  always @(posedge clk) begin
    report_t want;
    if (!rst && report_ch.valid && report_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: value %0d div_fault %0b",
               report_ch.value, report_ch.div_fault);
        failures++;
      end else begin
        want = pending_reports.pop_front();
        if (report_ch.value !== want.value) begin
          $error("value: expected %0d, actual %0d", $signed(want.value), report_ch.value);
          failures++;
        end
        if (report_ch.div_fault !== want.div_fault) begin
          $error("div_fault: expected %0b, actual %0b", want.div_fault,
                 report_ch.div_fault);
          failures++;
        end
        reports_checked++;
        if (report_ch.div_fault) begin
          faults_seen++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (reading_ch.valid && reading_ch.ready) ||
        (report_ch.valid && report_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, then paced random segments.
  initial begin
    row_t row;
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= bcomp_pkg::REG_CAL_A;
    cfg_data               <= '0;
    reading_ch.valid       <= 1'b0;
    reading_ch.op          <= bcomp_pkg::OP_TEMP;
    reading_ch.raw_reading <= '0;
    send_idle_pct  = 22;
    recv_stall_pct = 72;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table; known rows carry their report, the rest use the model.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = STEPS[i];
      if (row.kind == ROW_CFG) begin
        if (i == 0 || STEPS[i - 1].kind != ROW_CFG) begin
          settle_block();
        end
        load_register(row.sel, row.word);
        if (i + 1 == DIRECTED_ROWS || STEPS[i + 1].kind != ROW_CFG) begin
          cfg_we <= 1'b0;
        end
      end else begin
        send_reading(row.op, row.raw, row.known, '{row.want_value, row.want_fault});
      end
    end

    // Three pacing modes, three calibration styles each.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0: begin
          send_idle_pct  = 22;
          recv_stall_pct = 72;
        end
        1: begin
          send_idle_pct  = 72;
          recv_stall_pct = 22;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      run_segment(seg, SEGMENT_ITEMS);
    end

    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d temperature and %0d pressure transactions with %0d register writes",
             temp_sent, press_sent, reg_writes);
    $display("over three pacing modes; %0d reports compared, %0d with a divisor fault.",
             reports_checked, faults_seen);
    if (failures == 0 && pending_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
